// File: rtl/core/battery_level_interp_hold_core_defines.svh
// assertion macros shared by the battery level core files
`ifndef BATTERY_LEVEL_INTERP_HOLD_CORE_DEFINES_SVH
`define BATTERY_LEVEL_INTERP_HOLD_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define BLI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bli assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define BLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bli assertion failed");

`else

`define BLI_ASSERT_IMPL(lbl, ante, cons)
`define BLI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/bli_pkg.sv
// widths, table constants, codes and shared types for the battery level core
package bli_pkg;

    localparam int TABLE_POINTS = 31;
    localparam int IDX_W        = 5;
    localparam int CODE_W       = 12;
    localparam int VREF_W       = 12;
    localparam int THR_W        = 8;
    localparam int PCT_W        = 8;
    localparam int MV_W         = 13;
    localparam int LVL_W        = 16;
    localparam int NUM_W        = 25;
    localparam int DIFF_W       = 24;
    localparam int PROD_W       = 32;
    localparam int MUL_P_W      = DIFF_W + VREF_W;
    localparam int FRAC_BITS    = 8;
    localparam int ADC_SHIFT    = 12;
    localparam int DIVIDEND_W   = 40;
    localparam int DIVISOR_W    = 24;
    localparam int QUOT_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [DIVISOR_W-1:0] ADC_FULL   = 24'd4095;
    localparam logic [LVL_W-1:0]     LEVEL_TOP  = 16'hFF00;
    localparam logic [LVL_W-1:0]     HELD_RESET = 16'd1075;
    localparam logic [VREF_W-1:0]    VREF_RESET = 12'd3300;
    localparam logic [THR_W-1:0]     THR_RESET  = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 2'd1;

    // table voltages fall along the index
    localparam logic [MV_W-1:0] SEG_MV [TABLE_POINTS] = '{
        13'd6700, 13'd4160, 13'd4150, 13'd4140, 13'd4120, 13'd4100, 13'd4080,
        13'd4050, 13'd4030, 13'd3970, 13'd3930, 13'd3900, 13'd3870, 13'd3840,
        13'd3810, 13'd3790, 13'd3770, 13'd3760, 13'd3740, 13'd3730, 13'd3720,
        13'd3710, 13'd3680, 13'd3660, 13'd3640, 13'd3620, 13'd3600, 13'd3550,
        13'd3500, 13'd3450, 13'd3400 };

    localparam logic [PCT_W-1:0] SEG_PCT [TABLE_POINTS] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd100, 8'd95, 8'd90,
        8'd85, 8'd80, 8'd75, 8'd70, 8'd65, 8'd60, 8'd55, 8'd50, 8'd48,
        8'd47, 8'd46, 8'd45, 8'd44, 8'd43, 8'd42, 8'd41, 8'd40, 8'd30,
        8'd24, 8'd18, 8'd12, 8'd6, 8'd0 };

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // table voltage times 4095, in the same scale as the adc product
    function automatic logic [NUM_W-1:0] seg_lo_num(input logic [IDX_W-1:0] idx);
        logic [NUM_W-1:0] v;
        v = NUM_W'(SEG_MV[idx]);
        return (v << ADC_SHIFT) - v;
    endfunction

    // segment width times 4095, only meaningful for a falling segment
    function automatic logic [DIVISOR_W-1:0] seg_span(input logic [IDX_W-1:0] idx);
        logic [DIVISOR_W-1:0] dv;
        logic [IDX_W-1:0]     nxt;
        nxt = idx + IDX_W'(1);
        dv  = DIVISOR_W'(SEG_MV[idx]) - DIVISOR_W'(SEG_MV[nxt]);
        return (dv << ADC_SHIFT) - dv;
    endfunction

endpackage

// File: rtl/core/battery_level_interp_hold_core.sv
// battery level core: adc scaling, table interpolation and level hold
//
//   channel | signals                                 | moves
//   --------+-----------------------------------------+----------------------------
//   in      | in_valid, in_stall, adc_code            | one adc sample word
//   out     | out_valid, out_stall, display_level,    | one level and voltage word
//           | battery_mv                              |
//   cfg     | cfg_we, cfg_index, cfg_data             | register write, no wait
//
// an input word goes through one multiply, a fold for the millivolts, a linear
// scan of one table segment per cycle, then a multiply and a 16-step divide for
// the fraction
// in_stall is high from acceptance until the result moves to the output register
// a stalled result waits in the output register; the next sample is taken meanwhile
// reset restores vref 3300, rise threshold 5 and a held level of 4.2
`include "battery_level_interp_hold_core_defines.svh"

module battery_level_interp_hold_core
    import bli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CODE_W-1:0]     adc_code,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PCT_W-1:0]      display_level,
    output logic [MV_W-1:0]       battery_mv,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_DIV1 = 7'b0000100,
        ST_SCAN = 7'b0001000,
        ST_MUL2 = 7'b0010000,
        ST_DIV2 = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [VREF_W-1:0]    vref_reg, vref_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [LVL_W-1:0]     held_reg, held_next;
    logic                 div_start_reg, div_start_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [MV_W-1:0]      mv_reg, mv_next;
    logic [IDX_W-1:0]     seg_reg, seg_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [PCT_W-1:0]     disp_reg, disp_next;
    logic [MV_W-1:0]      bmv_reg, bmv_next;

    logic [DIFF_W-1:0]    mul_a;
    logic [VREF_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]   mul_prod;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [QUOT_W-1:0]    div_quot;
    div_stat_t            div_stat;

    logic [MV_W-1:0]      fold_a;
    logic [ADC_SHIFT-1:0] fold_b;
    logic [MV_W:0]        fold_s;
    logic [MV_W-ADC_SHIFT:0] fold_c;
    logic [MV_W-1:0]      fold_t;
    logic [MV_W-1:0]      mv_fold;

    logic [IDX_W-1:0]     seg_nxt;
    logic [MV_W-1:0]      v_hi, v_lo;
    logic [PCT_W-1:0]     p_hi, p_lo, dl;
    logic                 seg_hit, seg_last;
    logic [NUM_W-1:0]     diff_full;
    logic                 in_acc, out_free;
    logic [LVL_W-1:0]     rise, held_upd;

    // one shared multiplier: adc code by vref, then offset by level step
    assign mul_a    = (state_reg == ST_MUL1) ? DIFF_W'(code_reg) : diff_full[DIFF_W-1:0];
    assign mul_b    = (state_reg == ST_MUL1) ? vref_reg : VREF_W'(dl);
    assign mul_prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    assign div_dividend = {prod_reg, {FRAC_BITS{1'b0}}};
    assign div_divisor  = seg_span(seg_reg);

    bli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // x / 4095 with x = 4096a + b is a + (a + b) / 4095, folded twice
    assign fold_a  = num_reg[NUM_W-1:ADC_SHIFT];
    assign fold_b  = num_reg[ADC_SHIFT-1:0];
    assign fold_s  = (MV_W+1)'(fold_a) + (MV_W+1)'(fold_b);
    assign fold_c  = fold_s[MV_W:ADC_SHIFT];
    assign fold_t  = MV_W'(fold_s[ADC_SHIFT-1:0]) + MV_W'(fold_c);
    assign mv_fold = fold_a + MV_W'(fold_c) + MV_W'(fold_t >= ADC_FULL[MV_W-1:0]);

    // segment under test: floor(mv) compares the same as the exact voltage
    assign seg_nxt   = seg_reg + IDX_W'(1);
    assign v_hi      = SEG_MV[seg_reg];
    assign v_lo      = SEG_MV[seg_nxt];
    assign p_hi      = SEG_PCT[seg_reg];
    assign p_lo      = SEG_PCT[seg_nxt];
    assign dl        = (p_hi >= p_lo) ? (p_hi - p_lo) : '0;
    assign seg_hit   = (v_hi > v_lo) && (mv_reg < v_hi) && (mv_reg >= v_lo);
    assign seg_last  = seg_reg == IDX_W'(TABLE_POINTS - 2);
    assign diff_full = num_reg - seg_lo_num(seg_nxt);

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign rise     = lvl_reg - held_reg;
    assign held_upd = (lvl_reg < held_reg) ? lvl_reg
                    : (rise > {thr_reg, {FRAC_BITS{1'b0}}}) ? lvl_reg : held_reg;

    always_comb
    begin
        state_next     = state_reg;
        vref_next      = vref_reg;
        thr_next       = thr_reg;
        held_next      = held_reg;
        div_start_next = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        code_next      = code_reg;
        num_next       = num_reg;
        mv_next        = mv_reg;
        seg_next       = seg_reg;
        prod_next      = prod_reg;
        lvl_next       = lvl_reg;
        disp_next      = disp_reg;
        bmv_next       = bmv_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VREF_MV:        vref_next = cfg_data[VREF_W-1:0];
                CFG_RISE_THRESHOLD: thr_next  = cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    code_next  = adc_code;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                num_next   = {mul_prod[NUM_W-2:0], 1'b0};
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                mv_next  = mv_fold;
                seg_next = '0;
                if (mv_fold >= SEG_MV[0])
                begin
                    lvl_next   = LEVEL_TOP;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (seg_hit)
                begin
                    state_next = ST_MUL2;
                end
                else if (seg_last)
                begin
                    // below the bottom point
                    lvl_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    seg_next = seg_nxt;
                end
            end
            ST_MUL2:
            begin
                prod_next      = mul_prod[PROD_W-1:0];
                div_start_next = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    lvl_next   = {p_lo, {FRAC_BITS{1'b0}}} + div_quot;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    held_next      = held_upd;
                    disp_next      = held_upd[LVL_W-1:FRAC_BITS];
                    bmv_next       = mv_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vref_reg      <= VREF_RESET;
            thr_reg       <= THR_RESET;
            held_reg      <= HELD_RESET;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vref_reg      <= vref_next;
            thr_reg       <= thr_next;
            held_reg      <= held_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        num_reg  <= num_next;
        mv_reg   <= mv_next;
        seg_reg  <= seg_next;
        prod_reg <= prod_next;
        lvl_reg  <= lvl_next;
        disp_reg <= disp_next;
        bmv_reg  <= bmv_next;
    end

    assign in_stall      = state_reg != ST_IDLE;
    assign out_valid     = out_valid_reg;
    assign display_level = disp_reg;
    assign battery_mv    = bmv_reg;

    `BLI_ASSERT_IMPL(a_div_done_in_div_state, div_stat.done, state_reg == ST_DIV2)
    `BLI_ASSERT_NEXT(a_accept_starts_mul, in_acc, state_reg == ST_MUL1)
    `BLI_ASSERT_IMPL(a_scan_index_bound, state_reg == ST_SCAN, seg_reg <= IDX_W'(TABLE_POINTS - 2))
    `BLI_ASSERT_IMPL(a_held_below_top, 1'b1, held_reg <= LEVEL_TOP)

endmodule

// File: rtl/core/bli_div.sv
// restoring divider, one quotient bit per cycle
`include "battery_level_interp_hold_core_defines.svh"

module bli_div
    import bli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUOT_W-1:0]     quotient,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dsh_reg, dsh_next;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // caller guarantees the quotient fits in QUOT_W bits
            rem_next  = dividend;
            dsh_next  = DIVIDEND_W'(divisor) << (QUOT_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            q_next   = {q_reg[QUOT_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `BLI_ASSERT_IMPL(a_div_no_restart, busy_reg, !start)
    `BLI_ASSERT_NEXT(a_div_last_step_done, busy_reg && !start && cnt_reg == CNT_W'(1), done_reg)

endmodule
